### src/cfp_pkg.sv
// ----------------------------------------------------------------------------
// cfp_pkg: shared definitions for the float calculator with prime test
// Operation and status codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package cfp_pkg;

  // Operation codes carried by an input item.
  localparam logic [2:0] OP_ADD   = 3'd1;
  localparam logic [2:0] OP_SUB   = 3'd2;
  localparam logic [2:0] OP_MUL   = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_MOD   = 3'd5;
  localparam logic [2:0] OP_PRIME = 3'd6;

  // Status codes of a result item.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_MODZERO = 2'd2;

  // Iteration counts of the shared divider.
  localparam logic [5:0] DIV_CNT_INT = 6'd32;
  localparam logic [5:0] DIV_CNT_FLT = 6'd27;

  // Exponent limits used by normalization and rounding, and exponent offsets of multiply and divide.
  localparam logic signed [10:0] E_COLLAPSE = -11'sd30;
  localparam logic signed [10:0] E_MAX      = 11'sd255;
  localparam logic signed [10:0] E_BIAS     = 11'sd127;
  localparam logic signed [10:0] E_DIV_ADJ  = 11'sd126;

  // First trial divisor of the prime test and its square.
  localparam logic [15:0] PRIME_FIRST    = 16'd2;
  localparam logic [32:0] PRIME_FIRST_SQ = 33'd4;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_DECODE,
    DP_PRENORM,
    DP_ADD,
    DP_MUL,
    DP_MULM,
    DP_FDIV_START,
    DP_FDIV_FIN,
    DP_NORM,
    DP_ROUND,
    DP_MOD_START,
    DP_MOD_FIN,
    DP_PTEST,
    DP_PDIV_START,
    DP_PCHECK,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       special;
    logic       ty_zero;
    logic       ty_m1;
    logic       tx_small;
    logic       pre_done;
    logic       norm_done;
    logic       div_busy;
    logic       sq_over;
    logic       rem_zero;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_PRENORM,
    S_ADD,
    S_MUL,
    S_MULM,
    S_FDIV_START,
    S_FDIV_WAIT,
    S_FDIV_FIN,
    S_NORM,
    S_ROUND,
    S_MOD_START,
    S_MOD_WAIT,
    S_MOD_FIN,
    S_PTEST,
    S_PDIV_START,
    S_PDIV_WAIT,
    S_PCHECK,
    S_DONE
  } ctrl_state_t;

endpackage

### src/cfp_in_if.sv
// ----------------------------------------------------------------------------
// cfp_in_if: input item channel
// Valid/ready channel carrying the operation code and two operands.
// ----------------------------------------------------------------------------
interface cfp_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] first_operand;
  logic [31:0] second_operand;

  modport source (output valid, cmd, first_operand, second_operand, input ready);
  modport sink (input valid, cmd, first_operand, second_operand, output ready);
endinterface

### src/cfp_out_if.sv
// ----------------------------------------------------------------------------
// cfp_out_if: result item channel
// Valid/ready channel carrying the float, integer and prime test results.
// ----------------------------------------------------------------------------
interface cfp_out_if;
  logic               valid;
  logic               ready;
  logic [31:0]        float_result;
  logic signed [31:0] int_result;
  logic               is_prime;
  logic [30:0]        smallest_factor;
  logic [30:0]        cofactor;
  logic [1:0]         status;

  modport source (output valid, float_result, int_result, is_prime, smallest_factor,
                  cofactor, status, input ready);
  modport sink (input valid, float_result, int_result, is_prime, smallest_factor,
                cofactor, status, output ready);
endinterface

### src/cfp_div.sv
// ----------------------------------------------------------------------------
// cfp_div: shared iterative restoring divider
// One quotient bit per cycle; the partial remainder may be preloaded.
// ----------------------------------------------------------------------------
module cfp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] r0,
  input  logic [31:0] dvd,
  input  logic [31:0] dvs,
  input  logic [5:0]  cnt,
  output logic        busy,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [5:0]  cnt_r;
  logic [31:0] rem_r, dvd_r, dvs_r, quo_r;
  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[31]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 6'd0;
    end else if (start) begin
      cnt_r <= cnt;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= r0;
      dvd_r <= dvd;
      dvs_r <= dvs;
      quo_r <= 32'd0;
    end else if (cnt_r != 6'd0) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[30:0], 1'b0};
      quo_r <= {quo_r[30:0], ge};
    end
  end

  assign busy = cnt_r != 6'd0;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

### src/cfp_dp.sv
// ----------------------------------------------------------------------------
// cfp_dp: calculator datapath
// Operand registers, float align/add, multiply, normalize and round steps,
// integer truncation, prime test counters, the shared divider and the result registers.
// ----------------------------------------------------------------------------
module cfp_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  cfp_pkg::dp_cmd_t   cmd,
  input  logic [2:0]         in_cmd,
  input  logic [31:0]        in_a,
  input  logic [31:0]        in_b,
  output cfp_pkg::dp_stat_t  stat,
  output logic [31:0]        float_result,
  output logic signed [31:0] int_result,
  output logic               is_prime,
  output logic [30:0]        smallest_factor,
  output logic [30:0]        cofactor,
  output logic [1:0]         status
);

  // Truncate toward zero with saturation; NaN gives zero.
  function automatic logic [31:0] trunc_sat(input logic [31:0] f);
    logic [7:0]  e;
    logic [31:0] m;
    logic [31:0] mag;
    logic [7:0]  sh;
    e   = f[30:23];
    m   = {8'd0, 1'b1, f[22:0]};
    mag = 32'd0;
    sh  = 8'd0;
    if (e == 8'hFF && f[22:0] != 23'd0) begin
      trunc_sat = 32'd0;
    end else if (e >= 8'd158) begin
      trunc_sat = f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (e < 8'd127) begin
      trunc_sat = 32'd0;
    end else begin
      if (e >= 8'd150) begin
        sh  = e - 8'd150;
        mag = m << sh[4:0];
      end else begin
        sh  = 8'd150 - e;
        mag = m >> sh[4:0];
      end
      trunc_sat = f[31] ? 32'd0 - mag : mag;
    end
  endfunction

  logic [2:0]  op_r;
  logic [31:0] a_r, b_r;
  logic [31:0] fres_r, ires_r;
  logic        prime_r;
  logic [30:0] fac_r, cof_r;
  logic [1:0]  stat_r;
  logic [31:0] o_fres_r, o_ires_r;
  logic        o_prime_r;
  logic [30:0] o_fac_r, o_cof_r;
  logic [1:0]  o_stat_r;

  logic [23:0]        pa_m_r, pb_m_r;
  logic signed [10:0] pa_e_r, pb_e_r;
  logic [47:0]        p_r;
  logic [27:0]        m_r;
  logic signed [10:0] e_r;
  logic               rs_r;
  logic [15:0]        i_r;
  logic [32:0]        sq_r;

  // Operand fields.
  logic       sa, sb, sbe;
  logic [7:0] ea, eb;
  logic       a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic       spec;
  logic [31:0] spec_val;
  logic       is_float_op;

  always_comb begin
    sa     = a_r[31];
    sb     = b_r[31];
    ea     = a_r[30:23];
    eb     = b_r[30:23];
    sbe    = (op_r == cfp_pkg::OP_SUB) ? ~sb : sb;
    a_nan  = ea == 8'hFF && a_r[22:0] != 23'd0;
    b_nan  = eb == 8'hFF && b_r[22:0] != 23'd0;
    a_inf  = ea == 8'hFF && a_r[22:0] == 23'd0;
    b_inf  = eb == 8'hFF && b_r[22:0] == 23'd0;
    a_zero = a_r[30:0] == 31'd0;
    b_zero = b_r[30:0] == 31'd0;
    is_float_op = op_r == cfp_pkg::OP_ADD || op_r == cfp_pkg::OP_SUB ||
                  op_r == cfp_pkg::OP_MUL || op_r == cfp_pkg::OP_DIV;
  end

  // Special operands: NaN propagation, infinities and zeros.
  always_comb begin
    spec     = 1'b0;
    spec_val = 32'd0;
    if (a_nan) begin
      spec     = 1'b1;
      spec_val = a_r | 32'h0040_0000;
    end else if (b_nan) begin
      spec     = 1'b1;
      spec_val = b_r | 32'h0040_0000;
    end else begin
      case (op_r)
        cfp_pkg::OP_ADD, cfp_pkg::OP_SUB: begin
          if (a_inf && b_inf && sa != sbe) begin
            spec     = 1'b1;
            spec_val = 32'hFFC0_0000;
          end else if (a_inf) begin
            spec     = 1'b1;
            spec_val = a_r;
          end else if (b_inf) begin
            spec     = 1'b1;
            spec_val = {sbe, 8'hFF, 23'd0};
          end
        end
        cfp_pkg::OP_MUL: begin
          if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            spec     = 1'b1;
            spec_val = 32'hFFC0_0000;
          end else if (a_inf || b_inf) begin
            spec     = 1'b1;
            spec_val = {sa ^ sb, 8'hFF, 23'd0};
          end else if (a_zero || b_zero) begin
            spec     = 1'b1;
            spec_val = {sa ^ sb, 31'd0};
          end
        end
        cfp_pkg::OP_DIV: begin
          if ((a_inf && b_inf) || (a_zero && b_zero)) begin
            spec     = 1'b1;
            spec_val = 32'hFFC0_0000;
          end else if (a_inf || b_zero) begin
            spec     = 1'b1;
            spec_val = {sa ^ sb, 8'hFF, 23'd0};
          end else if (b_inf || a_zero) begin
            spec     = 1'b1;
            spec_val = {sa ^ sb, 31'd0};
          end
        end
        default: begin
          spec = 1'b0;
        end
      endcase
    end
  end

  // Integer views of the operands.
  logic [31:0] tx, ty, ax, ay;
  always_comb begin
    tx = trunc_sat(a_r);
    ty = trunc_sat(b_r);
    ax = tx[31] ? 32'd0 - tx : tx;
    ay = ty[31] ? 32'd0 - ty : ty;
  end

  // Align and add: the larger magnitude sets the exponent.
  logic        a_big, eff_sub, sx;
  logic [7:0]  ex, ey, dexp;
  logic [23:0] mx, my;
  logic [4:0]  dsat;
  logic [27:0] mx_full, my_full, my_al, sum;
  logic [55:0] wide;

  always_comb begin
    a_big   = a_r[30:0] >= b_r[30:0];
    ex      = a_big ? ea : eb;
    ey      = a_big ? eb : ea;
    mx      = a_big ? {ea != 8'd0, a_r[22:0]} : {eb != 8'd0, b_r[22:0]};
    my      = a_big ? {eb != 8'd0, b_r[22:0]} : {ea != 8'd0, a_r[22:0]};
    sx      = a_big ? sa : sbe;
    if (ex == 8'd0) ex = 8'd1;
    if (ey == 8'd0) ey = 8'd1;
    dexp    = ex - ey;
    dsat    = (dexp > 8'd28) ? 5'd28 : dexp[4:0];
    mx_full = {1'b0, mx, 3'b000};
    my_full = {1'b0, my, 3'b000};
    wide    = {my_full, 28'd0} >> dsat;
    my_al   = {wide[55:29], wide[28] | (|wide[27:0])};
    eff_sub = sa ^ sbe;
    sum     = eff_sub ? mx_full - my_al : mx_full + my_al;
  end

  // One normalization step per cycle.
  logic [27:0]        m_nxt;
  logic signed [10:0] e_nxt;
  logic               norm_done;

  always_comb begin
    m_nxt     = m_r;
    e_nxt     = e_r;
    norm_done = 1'b0;
    if (m_r[27]) begin
      m_nxt = {1'b0, m_r[27:2], m_r[1] | m_r[0]};
      e_nxt = e_r + 11'sd1;
    end else if (e_r < cfp_pkg::E_COLLAPSE) begin
      m_nxt = {27'd0, |m_r};
      e_nxt = 11'sd1;
    end else if (e_r < 11'sd1) begin
      m_nxt = {1'b0, m_r[27:2], m_r[1] | m_r[0]};
      e_nxt = e_r + 11'sd1;
    end else if (!m_r[26] && e_r > 11'sd1 && m_r != 28'd0) begin
      m_nxt = {m_r[26:0], 1'b0};
      e_nxt = e_r - 11'sd1;
    end else begin
      norm_done = 1'b1;
    end
  end

  // Round to nearest even and pack.
  logic               inc;
  logic [24:0]        r25;
  logic [23:0]        mant;
  logic signed [10:0] ef;
  logic [31:0]        rnd_val;

  always_comb begin
    inc = m_r[2] & (m_r[3] | m_r[1] | m_r[0]);
    r25 = {1'b0, m_r[26:3]} + {24'd0, inc};
    if (r25[24]) begin
      mant = r25[24:1];
      ef   = e_r + 11'sd1;
    end else begin
      mant = r25[23:0];
      ef   = e_r;
    end
    if (ef >= cfp_pkg::E_MAX) begin
      rnd_val = {rs_r, 8'hFF, 23'd0};
    end else begin
      rnd_val = {rs_r, mant[23] ? ef[7:0] : 8'h00, mant[22:0]};
    end
  end

  // Shared divider.
  logic        div_start, div_busy;
  logic [31:0] div_r0, div_d, div_v, div_quo, div_rem;
  logic [5:0]  div_cnt;

  always_comb begin
    div_start = 1'b0;
    div_r0    = 32'd0;
    div_d     = 32'd0;
    div_v     = 32'd0;
    div_cnt   = cfp_pkg::DIV_CNT_INT;
    case (cmd.op)
      cfp_pkg::DP_FDIV_START: begin
        div_start = 1'b1;
        div_r0    = {9'd0, pa_m_r[23:1]};
        div_d     = {pa_m_r[0], 31'd0};
        div_v     = {8'd0, pb_m_r};
        div_cnt   = cfp_pkg::DIV_CNT_FLT;
      end
      cfp_pkg::DP_MOD_START: begin
        div_start = 1'b1;
        div_d     = ax;
        div_v     = ay;
      end
      cfp_pkg::DP_PDIV_START: begin
        div_start = 1'b1;
        div_d     = {1'b0, tx[30:0]};
        div_v     = {16'd0, i_r};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  cfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .r0    (div_r0),
    .dvd   (div_d),
    .dvs   (div_v),
    .cnt   (div_cnt),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  always_ff @(posedge clk) begin
    case (cmd.op)
      cfp_pkg::DP_LOAD: begin
        op_r    <= in_cmd;
        a_r     <= in_a;
        b_r     <= in_b;
        fres_r  <= 32'd0;
        ires_r  <= 32'd0;
        prime_r <= 1'b0;
        fac_r   <= 31'd0;
        cof_r   <= 31'd0;
        stat_r  <= cfp_pkg::STAT_OK;
      end
      cfp_pkg::DP_DECODE: begin
        pa_m_r <= {ea != 8'd0, a_r[22:0]};
        pb_m_r <= {eb != 8'd0, b_r[22:0]};
        pa_e_r <= signed'({3'b000, (ea == 8'd0) ? 8'd1 : ea});
        pb_e_r <= signed'({3'b000, (eb == 8'd0) ? 8'd1 : eb});
        i_r    <= cfp_pkg::PRIME_FIRST;
        sq_r   <= cfp_pkg::PRIME_FIRST_SQ;
        if (is_float_op) begin
          if (spec) begin
            fres_r <= spec_val;
          end
        end else if (op_r == cfp_pkg::OP_MOD) begin
          if (ty == 32'd0) begin
            stat_r <= cfp_pkg::STAT_MODZERO;
          end
        end else if (op_r == cfp_pkg::OP_PRIME) begin
          if ($signed(tx) <= 32'sd2) begin
            prime_r <= 1'b1;
          end
        end else begin
          stat_r <= cfp_pkg::STAT_INVALID;
        end
      end
      cfp_pkg::DP_PRENORM: begin
        if (!pa_m_r[23]) begin
          pa_m_r <= {pa_m_r[22:0], 1'b0};
          pa_e_r <= pa_e_r - 11'sd1;
        end
        if (!pb_m_r[23]) begin
          pb_m_r <= {pb_m_r[22:0], 1'b0};
          pb_e_r <= pb_e_r - 11'sd1;
        end
      end
      cfp_pkg::DP_ADD: begin
        m_r  <= sum;
        e_r  <= signed'({3'b000, ex});
        rs_r <= (sum == 28'd0) ? (sa & sbe) : sx;
      end
      cfp_pkg::DP_MUL: begin
        p_r <= pa_m_r * pb_m_r;
      end
      cfp_pkg::DP_MULM: begin
        m_r  <= {p_r[47:21], |p_r[20:0]};
        e_r  <= pa_e_r + pb_e_r - cfp_pkg::E_BIAS;
        rs_r <= sa ^ sb;
      end
      cfp_pkg::DP_FDIV_FIN: begin
        m_r  <= {div_quo[26:0], div_rem != 32'd0};
        e_r  <= pa_e_r - pb_e_r + cfp_pkg::E_DIV_ADJ;
        rs_r <= sa ^ sb;
      end
      cfp_pkg::DP_NORM: begin
        m_r <= m_nxt;
        e_r <= e_nxt;
      end
      cfp_pkg::DP_ROUND: begin
        fres_r <= rnd_val;
      end
      cfp_pkg::DP_MOD_FIN: begin
        ires_r <= tx[31] ? 32'd0 - div_rem : div_rem;
      end
      cfp_pkg::DP_PTEST: begin
        if (sq_r > {2'b00, tx[30:0]}) begin
          prime_r <= 1'b1;
        end
      end
      cfp_pkg::DP_PCHECK: begin
        if (div_rem == 32'd0) begin
          prime_r <= 1'b0;
          fac_r   <= {15'd0, i_r};
          cof_r   <= div_quo[30:0];
        end else begin
          i_r  <= i_r + 16'd1;
          sq_r <= sq_r + {16'd0, i_r, 1'b1};
        end
      end
      cfp_pkg::DP_PUBLISH: begin
        o_fres_r  <= fres_r;
        o_ires_r  <= ires_r;
        o_prime_r <= prime_r;
        o_fac_r   <= fac_r;
        o_cof_r   <= cof_r;
        o_stat_r  <= stat_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.op        = op_r;
    stat.special   = spec;
    stat.ty_zero   = ty == 32'd0;
    stat.ty_m1     = ty == 32'hFFFF_FFFF;
    stat.tx_small  = $signed(tx) <= 32'sd2;
    stat.pre_done  = pa_m_r[23] & pb_m_r[23];
    stat.norm_done = norm_done;
    stat.div_busy  = div_busy;
    stat.sq_over   = sq_r > {2'b00, tx[30:0]};
    stat.rem_zero  = div_rem == 32'd0;
  end

  assign float_result    = o_fres_r;
  assign int_result      = signed'(o_ires_r);
  assign is_prime        = o_prime_r;
  assign smallest_factor = o_fac_r;
  assign cofactor        = o_cof_r;
  assign status          = o_stat_r;

endmodule

### src/cfp_ctrl.sv
// ----------------------------------------------------------------------------
// cfp_ctrl: calculator controller
// Sequences the datapath steps for each operation and owns the handshakes.
// ----------------------------------------------------------------------------
module cfp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cfp_pkg::dp_cmd_t  cmd,
  input  cfp_pkg::dp_stat_t stat
);

  cfp_pkg::ctrl_state_t state_r, state_nxt;
  logic out_valid_r, out_free, publish;

  assign out_free = !out_valid_r || out_ready;
  assign publish  = state_r == cfp_pkg::S_DONE && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfp_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cfp_pkg::S_DECODE;
      end
      cfp_pkg::S_DECODE: begin
        case (stat.op)
          cfp_pkg::OP_ADD, cfp_pkg::OP_SUB:
            state_nxt = stat.special ? cfp_pkg::S_DONE : cfp_pkg::S_ADD;
          cfp_pkg::OP_MUL, cfp_pkg::OP_DIV:
            state_nxt = stat.special ? cfp_pkg::S_DONE : cfp_pkg::S_PRENORM;
          cfp_pkg::OP_MOD:
            state_nxt = (stat.ty_zero || stat.ty_m1) ? cfp_pkg::S_DONE
                                                     : cfp_pkg::S_MOD_START;
          cfp_pkg::OP_PRIME:
            state_nxt = stat.tx_small ? cfp_pkg::S_DONE : cfp_pkg::S_PTEST;
          default:
            state_nxt = cfp_pkg::S_DONE;
        endcase
      end
      cfp_pkg::S_PRENORM: begin
        if (stat.pre_done) begin
          state_nxt = (stat.op == cfp_pkg::OP_MUL) ? cfp_pkg::S_MUL
                                                   : cfp_pkg::S_FDIV_START;
        end
      end
      cfp_pkg::S_ADD:        state_nxt = cfp_pkg::S_NORM;
      cfp_pkg::S_MUL:        state_nxt = cfp_pkg::S_MULM;
      cfp_pkg::S_MULM:       state_nxt = cfp_pkg::S_NORM;
      cfp_pkg::S_FDIV_START: state_nxt = cfp_pkg::S_FDIV_WAIT;
      cfp_pkg::S_FDIV_WAIT: begin
        if (!stat.div_busy) state_nxt = cfp_pkg::S_FDIV_FIN;
      end
      cfp_pkg::S_FDIV_FIN:   state_nxt = cfp_pkg::S_NORM;
      cfp_pkg::S_NORM: begin
        if (stat.norm_done) state_nxt = cfp_pkg::S_ROUND;
      end
      cfp_pkg::S_ROUND:      state_nxt = cfp_pkg::S_DONE;
      cfp_pkg::S_MOD_START:  state_nxt = cfp_pkg::S_MOD_WAIT;
      cfp_pkg::S_MOD_WAIT: begin
        if (!stat.div_busy) state_nxt = cfp_pkg::S_MOD_FIN;
      end
      cfp_pkg::S_MOD_FIN:    state_nxt = cfp_pkg::S_DONE;
      cfp_pkg::S_PTEST: begin
        state_nxt = stat.sq_over ? cfp_pkg::S_DONE : cfp_pkg::S_PDIV_START;
      end
      cfp_pkg::S_PDIV_START: state_nxt = cfp_pkg::S_PDIV_WAIT;
      cfp_pkg::S_PDIV_WAIT: begin
        if (!stat.div_busy) state_nxt = cfp_pkg::S_PCHECK;
      end
      cfp_pkg::S_PCHECK: begin
        state_nxt = stat.rem_zero ? cfp_pkg::S_DONE : cfp_pkg::S_PTEST;
      end
      cfp_pkg::S_DONE: begin
        if (out_free) state_nxt = cfp_pkg::S_IDLE;
      end
      default: state_nxt = cfp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = cfp_pkg::DP_NOP;
    case (state_r)
      cfp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = cfp_pkg::DP_LOAD;
      end
      cfp_pkg::S_DECODE:     cmd.op = cfp_pkg::DP_DECODE;
      cfp_pkg::S_PRENORM:    cmd.op = cfp_pkg::DP_PRENORM;
      cfp_pkg::S_ADD:        cmd.op = cfp_pkg::DP_ADD;
      cfp_pkg::S_MUL:        cmd.op = cfp_pkg::DP_MUL;
      cfp_pkg::S_MULM:       cmd.op = cfp_pkg::DP_MULM;
      cfp_pkg::S_FDIV_START: cmd.op = cfp_pkg::DP_FDIV_START;
      cfp_pkg::S_FDIV_FIN:   cmd.op = cfp_pkg::DP_FDIV_FIN;
      cfp_pkg::S_NORM:       cmd.op = cfp_pkg::DP_NORM;
      cfp_pkg::S_ROUND:      cmd.op = cfp_pkg::DP_ROUND;
      cfp_pkg::S_MOD_START:  cmd.op = cfp_pkg::DP_MOD_START;
      cfp_pkg::S_MOD_FIN:    cmd.op = cfp_pkg::DP_MOD_FIN;
      cfp_pkg::S_PTEST:      cmd.op = cfp_pkg::DP_PTEST;
      cfp_pkg::S_PDIV_START: cmd.op = cfp_pkg::DP_PDIV_START;
      cfp_pkg::S_PCHECK:     cmd.op = cfp_pkg::DP_PCHECK;
      cfp_pkg::S_DONE: begin
        if (out_free) cmd.op = cfp_pkg::DP_PUBLISH;
      end
      default: cmd.op = cfp_pkg::DP_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cfp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (publish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

### src/float_calculator_with_prime_test.sv
// Invalid codes, float specials settled at decode and modulus by zero or minus one go
// from decode straight to the result; add/sub, mul, div and modulus take further steps
// (one bit a cycle in normalizer and divider).
// Prime test: one trial division per trial divisor, up to sqrt(value) divisors.
// One item at a time: the next item is taken the cycle after the result enters the
// output register. Synchronous active-low reset clears the controller and divider count.
// ----------------------------------------------------------------------------
// float_calculator_with_prime_test: four-function float ALU with remainder
// and primality test
// A controller state machine sequences a datapath that holds the operand,
// normalize/round and result registers and one shared iterative divider.
// ----------------------------------------------------------------------------
module float_calculator_with_prime_test (
  input  logic     clk,
  input  logic     rst_n,
  cfp_in_if.sink   in_ch,
  cfp_out_if.source out_ch
);

  // Command and status bundles between the controller and the datapath.
  cfp_pkg::dp_cmd_t  dp_cmd;
  cfp_pkg::dp_stat_t dp_stat;

  // The controller owns both handshakes. An item is taken only in the idle
  // state, and a finished result moves into the output register as soon as
  // that register is empty or being emptied.
  cfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // The datapath performs one step per command: float specials are settled
  // at decode, regular float results go through align/multiply/divide, then
  // normalize one bit per cycle and round to nearest even. The remainder and
  // the trial divisions of the prime test share the same divider.
  cfp_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .in_cmd          (in_ch.cmd),
    .in_a            (in_ch.first_operand),
    .in_b            (in_ch.second_operand),
    .stat            (dp_stat),
    .float_result    (out_ch.float_result),
    .int_result      (out_ch.int_result),
    .is_prime        (out_ch.is_prime),
    .smallest_factor (out_ch.smallest_factor),
    .cofactor        (out_ch.cofactor),
    .status          (out_ch.status)
  );

endmodule
